/* src/quaternion_to_rotation_matrix_defines.svh */
// Assertion helpers for quaternion_to_rotation_matrix.sv.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define QRM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define QRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/qrm_pkg.sv */
`timescale 1ns / 1ps

package qrm_pkg;

    // Output fraction bits
    localparam int FRAC_BITS = 14;

    // Matrix elements
    localparam int LANES = 9;

    // Field and datapath widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int PROD_W = 2 * IN_W;        // one component product
    localparam int SUM_W  = PROD_W + 1;      // sum of four squares, up to 2^32
    localparam int NUM_W  = PROD_W + 2;      // signed numerator
    localparam int MAG_W  = PROD_W + 1;      // numerator magnitude
    localparam int REM_W  = SUM_W;           // partial remainder, below the divisor
    localparam int QW     = FRAC_BITS + 1;   // quotient bits, up to 2^FRAC_BITS
    localparam int DW     = MAG_W + FRAC_BITS; // scaled dividend plus rounding term
    localparam int SAT_W  = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;

    // Saturation bounds and the identity diagonal
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] DIAG_ONE =
        (FRAC_BITS >= OUT_W - 1) ? OUT_MAX : OUT_W'(1 << FRAC_BITS);

    // Control traveling with each item
    typedef struct packed {
        logic valid;
        logic degen;
    } qrm_ctrl_t;

    // Divider state for all lanes
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][QW-1:0]    dlow;
        logic [LANES-1:0][QW-1:0]    quot;
        logic [LANES-1:0]            neg;
        logic [SUM_W-1:0]            den;
    } div_t;

endpackage

/* src/qrm_div_step.sv */
`timescale 1ns / 1ps

// One restoring-division step for all nine lanes, registered.
module qrm_div_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qrm_pkg::qrm_ctrl_t ctrl_i,
    input  qrm_pkg::div_t      data_i,
    output qrm_pkg::qrm_ctrl_t ctrl_o,
    output qrm_pkg::div_t      data_o
);
    import qrm_pkg::*;

    qrm_ctrl_t ctrl_reg;
    div_t      data_reg;
    div_t      data_next;

    logic [REM_W:0] trial [LANES];
    logic [REM_W:0] diff  [LANES];
    logic           ge    [LANES];

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        data_next = data_i;
        for (int i = 0; i < LANES; i++) begin
            trial[i] = {data_i.rem[i], data_i.dlow[i][QW-1]};
            diff[i]  = trial[i] - {1'b0, data_i.den};
            ge[i]    = (trial[i] >= {1'b0, data_i.den});
            data_next.rem[i]  = ge[i] ? diff[i][REM_W-1:0] : trial[i][REM_W-1:0];
            data_next.dlow[i] = {data_i.dlow[i][QW-2:0], 1'b0};
            data_next.quot[i] = {data_i.quot[i][QW-2:0], ge[i]};
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_i;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign data_o = data_reg;

endmodule

/* src/quaternion_to_rotation_matrix.sv */
`timescale 1ns / 1ps

// Quaternion to 3x3 rotation matrix. Each transaction on s_ carries one
// quaternion; each on m_ carries the nine row-major elements, each equal to
// round(N * 2^FRAC_BITS / S) with S the sum of squares, ties away from zero,
// saturated to 16 bits. An all-zero quaternion gives the identity and sets
// m_tuser. One quaternion is accepted per cycle while the skid register is
// empty. The pipeline is a product stage, a sum stage, a dividend setup stage,
// one restoring-division stage per quotient bit (FRAC_BITS + 1), and the
// output register. A skid register behind the output keeps s_tready registered and
// lets a new quaternion in while a finished result waits on m_tready.
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [63:0]    s_tdata,   // comp_x, comp_y, comp_z, comp_w
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [143:0]   m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic           m_tuser    // degenerate
);
    import qrm_pkg::*;

    localparam int TD_W = LANES * OUT_W;

    logic en;

    // Input fields
    logic signed [IN_W-1:0] comp_x, comp_y, comp_z, comp_w;
    assign comp_x = $signed(s_tdata[0*IN_W +: IN_W]);
    assign comp_y = $signed(s_tdata[1*IN_W +: IN_W]);
    assign comp_z = $signed(s_tdata[2*IN_W +: IN_W]);
    assign comp_w = $signed(s_tdata[3*IN_W +: IN_W]);

    // ---------------- Stage 1: products ----------------
    qrm_ctrl_t              p1_ctrl_reg, p1_ctrl_next;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic signed [PROD_W-1:0] xx_next, yy_next, zz_next, ww_next;
    logic signed [PROD_W-1:0] xy_next, zw_next, xz_next, yw_next, yz_next, xw_next;

    assign p1_ctrl_next.valid = s_tvalid;
    assign p1_ctrl_next.degen = (comp_x == '0) && (comp_y == '0) &&
                                (comp_z == '0) && (comp_w == '0);

    assign xx_next = PROD_W'(comp_x) * PROD_W'(comp_x);
    assign yy_next = PROD_W'(comp_y) * PROD_W'(comp_y);
    assign zz_next = PROD_W'(comp_z) * PROD_W'(comp_z);
    assign ww_next = PROD_W'(comp_w) * PROD_W'(comp_w);
    assign xy_next = PROD_W'(comp_x) * PROD_W'(comp_y);
    assign zw_next = PROD_W'(comp_z) * PROD_W'(comp_w);
    assign xz_next = PROD_W'(comp_x) * PROD_W'(comp_z);
    assign yw_next = PROD_W'(comp_y) * PROD_W'(comp_w);
    assign yz_next = PROD_W'(comp_y) * PROD_W'(comp_z);
    assign xw_next = PROD_W'(comp_x) * PROD_W'(comp_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_ctrl_reg <= '0;
        end else if (en) begin
            p1_ctrl_reg <= p1_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            ww_reg <= ww_next;
            xy_reg <= xy_next;
            zw_reg <= zw_next;
            xz_reg <= xz_next;
            yw_reg <= yw_next;
            yz_reg <= yz_next;
            xw_reg <= xw_next;
        end
    end

    // ---------------- Stage 2: norm and numerators ----------------
    qrm_ctrl_t               p2_ctrl_reg;
    logic [SUM_W-1:0]        s_reg, s_next;
    logic signed [NUM_W-1:0] num_reg  [LANES];
    logic signed [NUM_W-1:0] num_next [LANES];

    assign s_next = SUM_W'(xx_reg) + SUM_W'(yy_reg) + SUM_W'(zz_reg) + SUM_W'(ww_reg);

    always_comb begin
        num_next[0] = NUM_W'(xx_reg) + NUM_W'(ww_reg) - NUM_W'(yy_reg) - NUM_W'(zz_reg);
        num_next[1] = (NUM_W'(xy_reg) - NUM_W'(zw_reg)) <<< 1;
        num_next[2] = (NUM_W'(xz_reg) + NUM_W'(yw_reg)) <<< 1;
        num_next[3] = (NUM_W'(xy_reg) + NUM_W'(zw_reg)) <<< 1;
        num_next[4] = NUM_W'(yy_reg) + NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(zz_reg);
        num_next[5] = (NUM_W'(yz_reg) - NUM_W'(xw_reg)) <<< 1;
        num_next[6] = (NUM_W'(xz_reg) - NUM_W'(yw_reg)) <<< 1;
        num_next[7] = (NUM_W'(yz_reg) + NUM_W'(xw_reg)) <<< 1;
        num_next[8] = NUM_W'(zz_reg) + NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(yy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_ctrl_reg <= '0;
        end else if (en) begin
            p2_ctrl_reg <= p1_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg   <= s_next;
            num_reg <= num_next;
        end
    end

    // ---------------- Stage 3: sign, magnitude, rounded dividend ----------------
    qrm_ctrl_t        p3_ctrl_reg;
    div_t             p3_data_reg, p3_data_next;
    logic [NUM_W-1:0] neg_num [LANES];
    logic [MAG_W-1:0] mag     [LANES];
    logic [DW-1:0]    dvd     [LANES];

    always_comb begin
        p3_data_next     = '0;
        p3_data_next.den = s_reg;
        for (int i = 0; i < LANES; i++) begin
            neg_num[i] = -num_reg[i];
            mag[i]     = num_reg[i][NUM_W-1] ? neg_num[i][MAG_W-1:0]
                                             : num_reg[i][MAG_W-1:0];
            dvd[i]     = (DW'(mag[i]) << FRAC_BITS) + DW'(s_reg >> 1);
            p3_data_next.neg[i]  = num_reg[i][NUM_W-1];
            p3_data_next.rem[i]  = REM_W'(dvd[i][DW-1:QW]);
            p3_data_next.dlow[i] = dvd[i][QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_ctrl_reg <= '0;
        end else if (en) begin
            p3_ctrl_reg <= p2_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_data_reg <= p3_data_next;
        end
    end

    // ---------------- Divider: one quotient bit per stage ----------------
    qrm_ctrl_t chain_ctrl [QW+1];
    div_t      chain_data [QW+1];

    assign chain_ctrl[0] = p3_ctrl_reg;
    assign chain_data[0] = p3_data_reg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        qrm_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctrl_i  (chain_ctrl[k]),
            .data_i  (chain_data[k]),
            .ctrl_o  (chain_ctrl[k+1]),
            .data_o  (chain_data[k+1])
        );
    end

    // ---------------- Sign, saturate, identity override ----------------
    qrm_ctrl_t               tail_ctrl;
    logic [TD_W-1:0]         tail_tdata;
    logic signed [QW:0]      sval [LANES];
    logic signed [SAT_W-1:0] wide [LANES];
    logic signed [OUT_W-1:0] elem [LANES];

    assign tail_ctrl = chain_ctrl[QW];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sval[i] = chain_data[QW].neg[i] ? -$signed({1'b0, chain_data[QW].quot[i]})
                                            :  $signed({1'b0, chain_data[QW].quot[i]});
            wide[i] = SAT_W'(sval[i]);
            if (wide[i] > SAT_W'(OUT_MAX)) begin
                elem[i] = OUT_MAX;
            end else if (wide[i] < SAT_W'(OUT_MIN)) begin
                elem[i] = OUT_MIN;
            end else begin
                elem[i] = OUT_W'(wide[i]);
            end
            if (tail_ctrl.degen) begin
                elem[i] = (i % 4 == 0) ? DIAG_ONE : '0;
            end
            tail_tdata[i*OUT_W +: OUT_W] = elem[i];
        end
    end

    // ---------------- Output register and skid ----------------
    logic            m_tvalid_reg, m_tvalid_next;
    logic [TD_W-1:0] m_tdata_reg,  m_tdata_next;
    logic            m_tuser_reg,  m_tuser_next;
    logic            skid_valid_reg, skid_valid_next;
    logic [TD_W-1:0] skid_tdata_reg, skid_tdata_next;
    logic            skid_tuser_reg, skid_tuser_next;
    logic            tail_xfer;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign tail_xfer = en && tail_ctrl.valid;

    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        skid_valid_next = skid_valid_reg;
        skid_tdata_next = skid_tdata_reg;
        skid_tuser_next = skid_tuser_reg;
        if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tvalid_next   = 1'b1;
                m_tdata_next    = skid_tdata_reg;
                m_tuser_next    = skid_tuser_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_tvalid_next = tail_xfer;
                m_tdata_next  = tail_tdata;
                m_tuser_next  = tail_ctrl.degen;
            end
        end else if (tail_xfer) begin
            skid_valid_next = 1'b1;
            skid_tdata_next = tail_tdata;
            skid_tuser_next = tail_ctrl.degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        skid_tdata_reg <= skid_tdata_next;
        skid_tuser_reg <= skid_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- Assertions ----------------
    // identity pattern on m00, m01 and the center element
    logic ident_out;
    assign ident_out = (m_tdata[0 +: OUT_W] == DIAG_ONE) && (m_tdata[OUT_W +: OUT_W] == '0) &&
                       (m_tdata[4*OUT_W +: OUT_W] == DIAG_ONE);

    `QRM_ASSERT_NEXT(a_accept_enters_pipe, s_tvalid && s_tready, p1_ctrl_reg.valid)
    `QRM_ASSERT_IMPL(a_skid_behind_output, skid_valid_reg, m_tvalid)
    `QRM_ASSERT_IMPL(a_skid_fills_on_stall, $rose(skid_valid_reg), $past(m_tvalid && !m_tready))
    `QRM_ASSERT_IMPL(a_degenerate_identity, m_tvalid && m_tuser, ident_out)

endmodule

/* tb/sv/rotation_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the rotation matrix for every accepted
// quaternion and compares each result transaction against the oldest one.
module rotation_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [63:0]    s_tdata,   // comp_x, comp_y, comp_z, comp_w
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [143:0]   m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic           m_tuser,   // degenerate
    output int             fail_count,
    output int             pending
);
    import qrm_pkg::*;

    typedef struct packed {
        logic                   degen;
        logic [LANES*OUT_W-1:0] elems;
    } rot_result_t;

    rot_result_t expected_mats[$];

    // round(num * 2^FRAC_BITS / den), ties away from zero, clamped to the field
    function automatic logic signed [OUT_W-1:0] ratio_to_fixed(input longint num,
                                                                input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< FRAC_BITS) + (den >>> 1)) / den;
        if (num < 0)
            q = -q;
        if (q > longint'(OUT_MAX))
            return OUT_MAX;
        if (q < longint'(OUT_MIN))
            return OUT_MIN;
        return OUT_W'(q);
    endfunction

    // Normalized rotation matrix of one quaternion
    function automatic rot_result_t predict_rotation(input logic [4*IN_W-1:0] q);
        longint x, y, z, w;
        longint xx, yy, zz, ww, s;
        longint num [LANES];
        rot_result_t r;
        x = longint'($signed(q[0*IN_W +: IN_W]));
        y = longint'($signed(q[1*IN_W +: IN_W]));
        z = longint'($signed(q[2*IN_W +: IN_W]));
        w = longint'($signed(q[3*IN_W +: IN_W]));
        xx = x * x;
        yy = y * y;
        zz = z * z;
        ww = w * w;
        s = xx + yy + zz + ww;
        r = '0;
        if (s == 0) begin
            // all-zero quaternion: identity, flagged
            r.degen = 1'b1;
            for (int i = 0; i < LANES; i++)
                r.elems[i*OUT_W +: OUT_W] = (i % 4 == 0) ? ratio_to_fixed(1, 1) : '0;
        end else begin
            num[0] = xx + ww - yy - zz;
            num[1] = 2 * (x * y - z * w);
            num[2] = 2 * (x * z + y * w);
            num[3] = 2 * (x * y + z * w);
            num[4] = yy + ww - xx - zz;
            num[5] = 2 * (y * z - x * w);
            num[6] = 2 * (x * z - y * w);
            num[7] = 2 * (y * z + x * w);
            num[8] = zz + ww - xx - yy;
            for (int i = 0; i < LANES; i++)
                r.elems[i*OUT_W +: OUT_W] = ratio_to_fixed(num[i], s);
        end
        return r;
    endfunction

    // Scoreboard: compare first, then queue the new prediction
    always @(posedge aclk) begin
        int errs;
        rot_result_t want;
        logic signed [OUT_W-1:0] want_e;
        logic signed [OUT_W-1:0] got_e;
        if (!aresetn) begin
            expected_mats.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            errs = 0;
            if (m_tvalid && m_tready) begin
                if (expected_mats.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h / %b",
                             $time, m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < LANES; i++) begin
                        want_e = want.elems[i*OUT_W +: OUT_W];
                        got_e  = m_tdata[i*OUT_W +: OUT_W];
                        if (got_e !== want_e) begin
                            $display("%0t: m%0d%0d expected %0d, got %0d",
                                     $time, i / 3, i % 3, want_e, got_e);
                            errs++;
                        end
                    end
                    if (m_tuser !== want.degen) begin
                        $display("%0t: degenerate expected %b, got %b",
                                 $time, want.degen, m_tuser);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_mats.push_back(predict_rotation(s_tdata));
            fail_count <= fail_count + errs;
            pending    <= expected_mats.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qrm_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_CYCLES  = 2 * (FRAC_BITS + 5);

    logic           aclk;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic [63:0]    s_tdata  = '0;
    logic           m_tready = 1'b0;
    logic           calm     = 1'b0;   // no idling on either side while set
    logic           s_tready;
    logic           m_tvalid;
    logic [143:0]   m_tdata;
    logic           m_tuser;
    int             fail_count;
    int             pending;

    quaternion_to_rotation_matrix DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rotation_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    function automatic logic [63:0] quat(input int x, input int y, input int z,
                                         input int w);
        return {16'(w), 16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [15:0] edge_value();
        case ($urandom_range(6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            4:       return 16'hFFFF;
            5:       return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic logic [15:0] tiny_value();
        return 16'(int'($urandom_range(16)) - 8);
    endfunction

    // Mix of full-range, tiny, boundary, near-axis and all-zero quaternions
    function automatic logic [63:0] random_quat();
        logic [63:0] q;
        case ($urandom_range(9))
            5, 6: q = {tiny_value(), tiny_value(), tiny_value(), tiny_value()};
            7:    q = {edge_value(), edge_value(), edge_value(), edge_value()};
            8: begin
                q = {tiny_value(), tiny_value(), tiny_value(), tiny_value()};
                q[16*$urandom_range(3) +: 16] = 16'($urandom);
            end
            9:    q = ($urandom_range(3) == 0) ? '0 : {$urandom, $urandom};
            default: q = {$urandom, $urandom};
        endcase
        return q;
    endfunction

    // One input transaction, with random idle cycles ahead of it
    task automatic send_quat(input logic [63:0] q);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= q;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [63:0] directed [$];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, axes, extremes, tiny and familiar rotations
        directed = '{
            quat(0, 0, 0, 0),
            quat(0, 0, 0, 16384),
            quat(0, 0, 0, -16384),
            quat(16384, 0, 0, 0),
            quat(0, 16384, 0, 0),
            quat(0, 0, 16384, 0),
            quat(-32768, -32768, -32768, -32768),
            quat(32767, 32767, 32767, 32767),
            quat(-32768, 0, 0, 0),
            quat(0, -32768, 0, 0),
            quat(0, 0, -32768, 0),
            quat(0, 0, 0, -32768),
            quat(32767, -32768, 32767, -32768),
            quat(1, 0, 0, 0),
            quat(0, 0, 0, -1),
            quat(1, 1, 1, 1),
            quat(1, 2, 3, 4),
            quat(-1, 2, -3, 4),
            quat(1, 1, 1, 0),
            quat(11585, 0, 0, 11585),
            quat(8192, 8192, 8192, 8192),
            quat(0, 0, 0, 0),
            quat(32767, 1, 0, 0)
        };
        foreach (directed[i])
            send_quat(directed[i]);
        drain();

        // random quaternions, one calm stretch, one full drain after item 250
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400)
                calm <= 1'b1;
            if (n == 600)
                calm <= 1'b0;
            if (n == 250)
                drain();
            send_quat(random_quat());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/qrm_pkg.sv
src/qrm_div_step.sv
src/quaternion_to_rotation_matrix.sv
tb/sv/rotation_checker.sv
tb/sv/tb.sv
